>>> design/polyline_scanline_edge_fill_macros.svh
// Assertion macros for the polyline scanline edge fill block.
`ifndef POLYLINE_SCANLINE_EDGE_FILL_MACROS_SVH
`define POLYLINE_SCANLINE_EDGE_FILL_MACROS_SVH
// Property checked at every clock edge outside reset.
`define PLSEF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition implies consequence in the next cycle.
`define PLSEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> design/plsef_pkg.sv
// Package for the polyline scanline edge fill block: state type, widths and config/action codes.
package plsef_pkg;
  localparam int CoordW = 10;
  localparam int PosW   = 21;
  localparam int QuotW  = 18;
  localparam int DcntW  = 5;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_WALK,
    S_RD
  } state_t;

  localparam logic CFG_EDGE_SELECT = 1'b0;
  localparam logic CFG_MAX_X       = 1'b1;
  localparam logic ACT_PUSH        = 1'b0;
  localparam logic ACT_READ        = 1'b1;
endpackage

>>> design/polyline_scanline_edge_fill.sv
// Polyline scanline edge fill: walks segments into a line table held in two byte memories.
// Push: no line is walked if there is no segment, or if the new vertex lies above the previous one;
//   else an 18-bit restoring division (skipped when dy is 0), then one scanline written per cycle.
// Read: the memory read is registered, then loaded into the output register in S_RD once it is free.
// Reset: synchronous, active low; then a clearing pass zeroes all TABLE_LINES lines with no input taken.
// Output register holds a result until taken; a new item is taken only in idle.
module polyline_scanline_edge_fill #(
  parameter int MAX_VERTICES = 8,
  parameter int TABLE_LINES  = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic signed [9:0] in_vertex_x,
  input  logic signed [9:0] in_vertex_y,
  input  logic              in_first_vertex,
  input  logic [7:0]        in_read_line,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_left_edge,
  output logic [7:0]        out_right_edge
);
`include "polyline_scanline_edge_fill_macros.svh"

  localparam int AW = $clog2(TABLE_LINES);
  localparam int VW = $clog2(MAX_VERTICES + 1);

  plsef_pkg::state_t state_r, state_nxt;

  logic              edge_sel_r;
  logic [7:0]        max_x_r;
  logic [AW-1:0]     clr_cnt_r;
  logic signed [9:0] prev_x_r, prev_y_r;
  logic [VW-1:0]     vcnt_r;
  logic signed [10:0] line_r, end_r;
  logic signed [20:0] pos_r;
  logic              neg_r;
  logic [17:0]       dq_r;
  logic [9:0]        rem_r, dvs_r;
  logic [4:0]        dcnt_r;

  logic [7:0] left_mem  [TABLE_LINES];
  logic [7:0] right_mem [TABLE_LINES];
  logic [7:0] rd_left_r, rd_right_r;
  logic       rd_ok_r;
  logic       out_valid_r;
  logic [7:0] out_left_r, out_right_r;

  logic accept, acc_read, acc_push, seg;
  logic signed [10:0] dx, dy;
  logic [9:0] dx_mag;
  logic [10:0] rem_s;
  logic div_ge;
  logic signed [20:0] step;
  logic line_ok, wr_left, wr_right;
  logic [AW-1:0] wr_addr;
  logic [7:0] wr_data;
  logic signed [12:0] lsh;
  logic [7:0] rval, lval;
  logic out_load;

  assign accept   = in_valid && !in_stall;
  assign acc_read = accept && (in_action == plsef_pkg::ACT_READ);
  assign acc_push = accept && (in_action == plsef_pkg::ACT_PUSH);
  assign seg      = !in_first_vertex && (vcnt_r != '0) && (vcnt_r < VW'(MAX_VERTICES));
  assign dx       = 11'(in_vertex_x) - 11'(prev_x_r);
  assign dy       = 11'(in_vertex_y) - 11'(prev_y_r);
  assign dx_mag   = dx[10] ? 10'(-dx) : dx[9:0];
  assign rem_s    = {rem_r, dq_r[17]};
  assign div_ge   = rem_s >= {1'b0, dvs_r};
  assign step     = neg_r ? -21'(dq_r) : 21'(dq_r);
  assign line_ok  = !line_r[10] && (32'(line_r[9:0]) < TABLE_LINES);
  assign lsh      = pos_r[20:8];
  assign rval     = (pos_r[15:8] > max_x_r) ? max_x_r : pos_r[15:8];
  assign lval     = lsh[12] ? 8'd0 : ((lsh > 13'(max_x_r)) ? max_x_r : lsh[7:0]);
  assign out_load = (state_r == plsef_pkg::S_RD) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plsef_pkg::S_CLEAR: begin
        if (clr_cnt_r == AW'(TABLE_LINES - 1)) state_nxt = plsef_pkg::S_IDLE;
      end
      plsef_pkg::S_IDLE: begin
        if (acc_read) begin
          state_nxt = plsef_pkg::S_RD;
        end else if (acc_push && seg && !dy[10]) begin
          state_nxt = (dy == '0) ? plsef_pkg::S_WALK : plsef_pkg::S_DIV;
        end
      end
      plsef_pkg::S_DIV: begin
        if (dcnt_r == 5'(plsef_pkg::QuotW - 1)) state_nxt = plsef_pkg::S_WALK;
      end
      plsef_pkg::S_WALK: begin
        if (line_r == end_r) state_nxt = plsef_pkg::S_IDLE;
      end
      plsef_pkg::S_RD: begin
        if (out_load) state_nxt = plsef_pkg::S_IDLE;
      end
      default: state_nxt = plsef_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    wr_left  = 1'b0;
    wr_right = 1'b0;
    wr_addr  = AW'(line_r[9:0]);
    wr_data  = 8'd0;
    case (state_r)
      plsef_pkg::S_CLEAR: begin
        wr_left  = 1'b1;
        wr_right = 1'b1;
        wr_addr  = clr_cnt_r;
      end
      plsef_pkg::S_IDLE: in_stall = 1'b0;
      plsef_pkg::S_WALK: begin
        wr_left  = line_ok && edge_sel_r;
        wr_right = line_ok && !edge_sel_r;
        wr_data  = edge_sel_r ? lval : rval;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_left) left_mem[wr_addr] <= wr_data;
    if (acc_read) rd_left_r <= left_mem[AW'(in_read_line)];
  end

  always_ff @(posedge clk) begin
    if (wr_right) right_mem[wr_addr] <= wr_data;
    if (acc_read) rd_right_r <= right_mem[AW'(in_read_line)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plsef_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      edge_sel_r  <= 1'b0;
      max_x_r     <= 8'd240;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      vcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == plsef_pkg::S_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cfg_we) begin
        case (cfg_index)
          plsef_pkg::CFG_EDGE_SELECT: edge_sel_r <= cfg_wdata[0];
          plsef_pkg::CFG_MAX_X:       max_x_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (acc_push) begin
        if (in_first_vertex || vcnt_r == '0) begin
          vcnt_r   <= VW'(1);
          prev_x_r <= in_vertex_x;
          prev_y_r <= in_vertex_y;
        end else if (seg) begin
          vcnt_r   <= vcnt_r + VW'(1);
          prev_x_r <= in_vertex_x;
          prev_y_r <= in_vertex_y;
        end
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_read) rd_ok_r <= 32'(in_read_line) < TABLE_LINES;
    if (out_load) begin
      out_left_r  <= rd_ok_r ? rd_left_r : 8'd0;
      out_right_r <= rd_ok_r ? rd_right_r : 8'd0;
    end
    if (acc_push && seg) begin
      line_r <= 11'(prev_y_r);
      end_r  <= 11'(in_vertex_y);
      pos_r  <= {{3{prev_x_r[9]}}, prev_x_r, 8'd0};
      neg_r  <= dx[10];
      dq_r   <= (dy == '0) ? 18'd0 : {dx_mag, 8'd0};
      rem_r  <= '0;
      dvs_r  <= dy[9:0];
      dcnt_r <= '0;
    end else if (state_r == plsef_pkg::S_DIV) begin
      rem_r  <= div_ge ? 10'(rem_s - {1'b0, dvs_r}) : rem_s[9:0];
      dq_r   <= {dq_r[16:0], div_ge};
      dcnt_r <= dcnt_r + 5'd1;
    end else if (state_r == plsef_pkg::S_WALK) begin
      pos_r  <= pos_r + step;
      line_r <= line_r + 11'sd1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_left_edge  = out_left_r;
  assign out_right_edge = out_right_r;

  `PLSEF_ASSERT_NEXT(a_read_goes_rd, acc_read, state_r == plsef_pkg::S_RD, "read not in RD")
  `PLSEF_ASSERT_ALWAYS(a_wr_in_table, (wr_left || wr_right) |-> (state_r == plsef_pkg::S_CLEAR || line_ok), "write outside table")
  `PLSEF_ASSERT_ALWAYS(a_vcnt_max, vcnt_r <= VW'(MAX_VERTICES), "vertex count overflow")
  `PLSEF_ASSERT_ALWAYS(a_out_from_rd, $rose(out_valid_r) |-> $past(state_r == plsef_pkg::S_RD), "result without read")
endmodule
